// ===== rtl/rmd_pkg.sv =====
package rmd_pkg;

    // widths of the serial divider
    localparam int unsigned NUM_W = 18;
    localparam int unsigned DEN_W = 14;

    localparam int unsigned OCTAVE_SHIFT_DEF = 0;

    // characters with a meaning in the melody string
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_O  = 8'h6F;
    localparam logic [7:0] CH_LC_B  = 8'h62;

    localparam logic [13:0] NUM_LIMIT   = 14'd9999;
    localparam logic [17:0] WHOLE_RESET = 18'd3808;
    localparam logic [17:0] MS_PER_MIN  = 18'd60000;

    typedef struct packed {
        logic [3:0]  semi;
        logic [3:0]  oct;
        logic [18:0] dur;
        logic        fault;
    } t_evt;

    function automatic logic [3:0] letter_value(input logic [7:0] c);
        logic [3:0] v;
        unique case (c)
            8'h63:   v = 4'd1;
            8'h64:   v = 4'd3;
            8'h65:   v = 4'd5;
            8'h66:   v = 4'd6;
            8'h67:   v = 4'd8;
            8'h61:   v = 4'd10;
            8'h62:   v = 4'd12;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== rtl/rmd_div.sv =====
module rmd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rmd_pkg::NUM_W-1:0]  i_num,
    input  logic [rmd_pkg::DEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [rmd_pkg::NUM_W-1:0]  o_quot
);
    import rmd_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_q;
    logic             r_done;

    logic [DEN_W:0] w_trial;
    logic           w_ge;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= i_num;
            end else if (r_busy) begin
                r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/rtttl_melody_decoder_top.sv =====
// rtttl melody decoder
// input channel: one ringtone character per word on i_melody_char, with
// i_end_of_melody set on the final character; taken when i_valid is high
// and o_stall is low. o_stall is high while a character is being worked on.
// output channel: one note event per word (rest flag, semitone, octave,
// pitch index and its valid flag, duration in ms, tempo fault, last flag),
// held in an output register and taken when o_valid is high and i_stall low.
// a character that falls in the skip after d=, o= or b= goes straight to the
// finish state; any other one is replayed through the parse steps until one
// takes it. a note letter and the end of a nonzero b= value also start the
// serial divider, one quotient bit per cycle over 18 bits.
// at most two events follow one character; an event waits in the output
// register while the receiver stalls, and the parser waits for it.
// when the closing character also starts the next note's division, the
// closed note's event is loaded only after that division.
// reset (synchronous, active low) returns the parser to the name skip with
// defaults duration 4, octave 6 and 63 bpm; the end flag does the same once
// its events are handed over.
module rtttl_melody_decoder_top #(
    parameter int unsigned OCTAVE_SHIFT = rmd_pkg::OCTAVE_SHIFT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_melody_char,
    input  logic        i_end_of_melody,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_rest,
    output logic [3:0]  o_semitone,
    output logic [3:0]  o_octave,
    output logic [5:0]  o_pitch_index,
    output logic        o_index_valid,
    output logic [18:0] o_duration_ms,
    output logic        o_tempo_fault,
    output logic        o_last_note
);
    import rmd_pkg::*;

    typedef enum logic [3:0] {
        PH_NAME, PH_D_CHECK, PH_D_NUM, PH_O_CHECK, PH_O_DIG, PH_B_CHECK, PH_B_NUM,
        PH_N_DUR, PH_N_SHARP, PH_N_DOT, PH_N_SCALE, PH_N_COMMA
    } t_phase;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_FIN} t_state;

    t_state      r_st;
    t_phase      r_ph;
    logic [1:0]  r_skip;
    logic [13:0] r_acc;
    logic [7:0]  r_ddiv;
    logic [3:0]  r_doct;
    logic [17:0] r_whole;
    logic [3:0]  r_psemi;
    logic [3:0]  r_poct;
    logic [18:0] r_pdur;
    logic        r_fault;
    logic [7:0]  r_c;
    logic        r_end;
    t_evt        r_held;
    logic        r_held_v;
    logic        r_ov;
    logic        r_dv_start;
    logic [NUM_W-1:0] r_dv_num;
    logic [DEN_W-1:0] r_dv_den;

    logic             w_dv_done;
    logic [NUM_W-1:0] w_dv_quot;

    // decimal accumulate with saturation
    logic [16:0] w_acc_mul;
    logic [13:0] w_acc_next;
    logic        w_dig;
    logic [13:0] w_note_div;
    logic        w_end_ev;
    t_evt        w_end_evt;
    t_evt        w_cur_evt;

    assign w_dig      = is_digit(r_c);
    assign w_acc_mul  = 17'({3'b000, r_acc} * 17'd10) + 17'({4'h0, r_c[3:0]});
    assign w_acc_next = (w_acc_mul > 17'(NUM_LIMIT)) ? NUM_LIMIT : w_acc_mul[13:0];
    assign w_note_div = (r_acc != 14'd0) ? r_acc :
                        (r_ddiv != 8'd0) ? {6'd0, r_ddiv} : 14'd1;
    assign w_end_ev   = r_end && (r_ph >= PH_N_SHARP);
    assign w_cur_evt  = '{semi: r_psemi, oct: r_poct, dur: r_pdur, fault: r_fault};
    assign w_end_evt  = '{semi: r_psemi, oct: (r_ph == PH_N_COMMA) ? r_poct : r_doct,
                          dur: r_pdur, fault: r_fault};

    // event fields from a snapshot
    logic [3:0]        w_ld_oct;
    logic signed [9:0] w_ld_idx;
    logic              w_ld_ok;
    t_evt              w_ld;

    assign w_ld     = r_held_v ? r_held : w_end_evt;
    assign w_ld_oct = w_ld.oct + 4'(OCTAVE_SHIFT);
    assign w_ld_idx = 10'($signed({6'd0, w_ld_oct}) - 10'sd4) * 10'sd12
                      + $signed({6'd0, w_ld.semi});
    assign w_ld_ok  = (w_ld.semi != 4'd0) && (w_ld_idx >= 10'sd1) && (w_ld_idx <= 10'sd48);

    rmd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dv_start),
        .i_num   (r_dv_num),
        .i_den   (r_dv_den),
        .o_done  (w_dv_done),
        .o_quot  (w_dv_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_IDLE;
            r_ph       <= PH_NAME;
            r_skip     <= '0;
            r_acc      <= '0;
            r_ddiv     <= 8'd4;
            r_doct     <= 4'd6;
            r_whole    <= WHOLE_RESET;
            r_psemi    <= '0;
            r_poct     <= '0;
            r_pdur     <= '0;
            r_fault    <= 1'b0;
            r_held_v   <= 1'b0;
            r_ov       <= 1'b0;
            r_dv_start <= 1'b0;
        end else begin
            r_dv_start <= 1'b0;
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_c   <= i_melody_char;
                        r_end <= i_end_of_melody;
                        if (r_skip != 2'd0) begin
                            r_skip <= r_skip - 2'd1;
                            r_st   <= ST_FIN;
                        end else begin
                            r_st <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    // one parse step per cycle; staying here replays the word
                    unique case (r_ph)
                        PH_NAME: begin
                            if (r_c == CH_COLON) r_ph <= PH_D_CHECK;
                            r_st <= ST_FIN;
                        end
                        PH_D_CHECK: begin
                            if (r_c == CH_LC_D) begin
                                r_skip <= 2'd1;
                                r_acc  <= '0;
                                r_ph   <= PH_D_NUM;
                                r_st   <= ST_FIN;
                            end else begin
                                r_ph <= PH_O_CHECK;
                            end
                        end
                        PH_D_NUM: begin
                            if (w_dig) begin
                                r_acc <= w_acc_next;
                            end else begin
                                if (r_acc != 14'd0) begin
                                    r_ddiv <= (r_acc > 14'd255) ? 8'd255 : r_acc[7:0];
                                end
                                r_ph <= PH_O_CHECK;
                            end
                            r_st <= ST_FIN;
                        end
                        PH_O_CHECK: begin
                            if (r_c == CH_LC_O) begin
                                r_skip <= 2'd1;
                                r_ph   <= PH_O_DIG;
                                r_st   <= ST_FIN;
                            end else begin
                                r_ph <= PH_B_CHECK;
                            end
                        end
                        PH_O_DIG: begin
                            if (r_c >= CH_THREE && r_c <= CH_SEVEN) r_doct <= r_c[3:0];
                            r_skip <= 2'd1;
                            r_ph   <= PH_B_CHECK;
                            r_st   <= ST_FIN;
                        end
                        PH_B_CHECK: begin
                            r_acc <= '0;
                            if (r_c == CH_LC_B) begin
                                r_skip <= 2'd1;
                                r_ph   <= PH_B_NUM;
                                r_st   <= ST_FIN;
                            end else begin
                                r_ph <= PH_N_DUR;
                            end
                        end
                        PH_B_NUM: begin
                            if (w_dig) begin
                                r_acc <= w_acc_next;
                                r_st  <= ST_FIN;
                            end else if (r_acc == 14'd0) begin
                                r_fault <= 1'b1;
                                r_whole <= '0;
                                r_ph    <= PH_N_DUR;
                                r_st    <= ST_FIN;
                            end else begin
                                r_fault    <= 1'b0;
                                r_dv_num   <= MS_PER_MIN;
                                r_dv_den   <= r_acc;
                                r_dv_start <= 1'b1;
                                r_st       <= ST_DIV;
                            end
                        end
                        PH_N_DUR: begin
                            if (w_dig) begin
                                r_acc <= w_acc_next;
                                r_st  <= ST_FIN;
                            end else begin
                                r_dv_num   <= r_whole;
                                r_dv_den   <= w_note_div;
                                r_dv_start <= 1'b1;
                                r_st       <= ST_DIV;
                            end
                        end
                        PH_N_SHARP: begin
                            r_ph <= PH_N_DOT;
                            if (r_c == CH_SHARP) begin
                                r_psemi <= r_psemi + 4'd1;
                                r_st    <= ST_FIN;
                            end
                        end
                        PH_N_DOT: begin
                            r_ph <= PH_N_SCALE;
                            if (r_c == CH_DOT) begin
                                r_pdur <= r_pdur + {1'b0, r_pdur[18:1]};
                                r_st   <= ST_FIN;
                            end
                        end
                        PH_N_SCALE: begin
                            r_ph <= PH_N_COMMA;
                            if (w_dig) begin
                                r_poct <= r_c[3:0];
                                r_st   <= ST_FIN;
                            end else begin
                                r_poct <= r_doct;
                            end
                        end
                        PH_N_COMMA: begin
                            // note closed: park it until the word is done
                            r_held   <= w_cur_evt;
                            r_held_v <= 1'b1;
                            r_acc    <= '0;
                            r_ph     <= PH_N_DUR;
                            if (r_c == CH_COMMA) r_st <= ST_FIN;
                        end
                        default: r_st <= ST_FIN;
                    endcase
                end
                ST_DIV: begin
                    if (w_dv_done) begin
                        if (r_ph == PH_B_NUM) begin
                            r_whole <= {w_dv_quot[NUM_W-3:0], 2'b00};
                            r_acc   <= '0;
                            r_ph    <= PH_N_DUR;
                        end else begin
                            r_pdur  <= {1'b0, w_dv_quot};
                            r_psemi <= letter_value(r_c);
                            r_ph    <= PH_N_SHARP;
                        end
                        r_st <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (r_held_v || w_end_ev) begin
                        if (!r_ov) begin
                            r_ov          <= 1'b1;
                            o_is_rest     <= (w_ld.semi == 4'd0);
                            o_semitone    <= w_ld.semi;
                            o_octave      <= w_ld_oct;
                            o_pitch_index <= w_ld_ok ? w_ld_idx[5:0] : 6'd0;
                            o_index_valid <= w_ld_ok;
                            o_duration_ms <= w_ld.dur;
                            o_tempo_fault <= w_ld.fault;
                            if (r_held_v) begin
                                r_held_v    <= 1'b0;
                                o_last_note <= r_end && !w_end_ev;
                                if (!w_end_ev) begin
                                    r_st <= ST_IDLE;
                                end
                            end else begin
                                o_last_note <= 1'b1;
                                r_st        <= ST_IDLE;
                            end
                            if (r_end && (!r_held_v || !w_end_ev)) begin
                                r_ph    <= PH_NAME;
                                r_skip  <= '0;
                                r_acc   <= '0;
                                r_ddiv  <= 8'd4;
                                r_doct  <= 4'd6;
                                r_whole <= WHOLE_RESET;
                                r_psemi <= '0;
                                r_poct  <= '0;
                                r_pdur  <= '0;
                                r_fault <= 1'b0;
                            end
                        end
                    end else begin
                        if (r_end) begin
                            r_ph    <= PH_NAME;
                            r_skip  <= '0;
                            r_acc   <= '0;
                            r_ddiv  <= 8'd4;
                            r_doct  <= 4'd6;
                            r_whole <= WHOLE_RESET;
                            r_psemi <= '0;
                            r_poct  <= '0;
                            r_pdur  <= '0;
                            r_fault <= 1'b0;
                        end
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_stall = (r_st != ST_IDLE);
    assign o_valid = r_ov;

`ifndef SYNTHESIS
    a_idx_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> ((o_pitch_index != 6'd0) == o_index_valid))
        else $error("pitch index and its valid flag disagree");
    a_rest_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(o_is_rest && o_index_valid))
        else $error("rest with a valid pitch index");
    a_held_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_v |-> (r_st != ST_IDLE))
        else $error("parked note left behind at idle");
    a_fault_dur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && o_tempo_fault) |-> (o_duration_ms == 19'd0))
        else $error("nonzero duration under tempo fault");
`endif

endmodule

// ===== tb/rmd_checker.sv =====
module rmd_checker #(
    parameter int unsigned OCTAVE_SHIFT = rmd_pkg::OCTAVE_SHIFT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_melody_char,
    input  logic        i_end_of_melody,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_is_rest,
    input  logic [3:0]  i_semitone,
    input  logic [3:0]  i_octave,
    input  logic [5:0]  i_pitch_index,
    input  logic        i_index_valid,
    input  logic [18:0] i_duration_ms,
    input  logic        i_tempo_fault,
    input  logic        i_last_note,
    output int          o_fails,
    output int          o_pending
);
    import rmd_pkg::*;

    typedef enum logic [3:0] {
        P_NAME, P_D_CHECK, P_D_NUM, P_O_CHECK, P_O_DIG, P_B_CHECK, P_B_NUM,
        P_N_DUR, P_N_SHARP, P_N_DOT, P_N_SCALE, P_N_COMMA
    } phase_e;

    typedef struct packed {
        logic        rest;
        logic [3:0]  semi;
        logic [3:0]  oct;
        logic [5:0]  idx;
        logic        ivalid;
        logic [18:0] dur;
        logic        fault;
        logic        last;
    } note_t;

    phase_e      phase;
    int unsigned skip_left, acc, def_div, def_oct, whole_ms;
    int unsigned p_semi, p_oct, p_dur;
    bit          fault;
    note_t       note_q[$];
    int          fails = 0;

    assign o_fails   = fails;
    assign o_pending = note_q.size();

    function automatic bit digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic int unsigned note_letter(input logic [7:0] c);
        case (c)
            "c": return 1;
            "d": return 3;
            "e": return 5;
            "f": return 6;
            "g": return 8;
            "a": return 10;
            "b": return 12;
            default: return 0;
        endcase
    endfunction

    task automatic clear_song();
        phase = P_NAME; skip_left = 0; acc = 0; def_div = 4; def_oct = 6;
        whole_ms = 3808; p_semi = 0; p_oct = 0; p_dur = 0; fault = 0;
    endtask

    task automatic add_digit(input logic [7:0] c);
        int unsigned v;
        v = acc * 10 + (c - 8'h30);
        acc = v > 9999 ? 9999 : v;
    endtask

    task automatic queue_note();
        note_t n;
        int    ix;
        n.semi   = p_semi[3:0];
        n.oct    = 4'((p_oct + OCTAVE_SHIFT) & 15);
        ix       = (int'(n.oct) - 4) * 12 + int'(n.semi);
        n.ivalid = n.semi != 0 && ix >= 1 && ix <= 48;
        n.idx    = n.ivalid ? 6'(ix) : 6'd0;
        n.rest   = n.semi == 0;
        n.dur    = 19'(p_dur);
        n.fault  = fault;
        n.last   = 1'b0;
        note_q.push_back(n);
    endtask

    // walks one character through the parse phases, queues the notes it closes
    task automatic decode_char(input logic [7:0] c, input logic last);
        bit          again;
        int unsigned div;
        int          q_start;
        q_start = note_q.size();
        if (skip_left != 0) begin
            skip_left--;
        end else begin
            do begin
                again = 0;
                case (phase)
                    P_NAME: if (c == CH_COLON) phase = P_D_CHECK;
                    P_D_CHECK: begin
                        if (c == CH_LC_D) begin
                            skip_left = 1; acc = 0; phase = P_D_NUM;
                        end else begin
                            phase = P_O_CHECK; again = 1;
                        end
                    end
                    P_D_NUM: begin
                        if (digit(c)) add_digit(c);
                        else begin
                            if (acc > 0) def_div = acc > 255 ? 255 : acc;
                            phase = P_O_CHECK;
                        end
                    end
                    P_O_CHECK: begin
                        if (c == CH_LC_O) begin
                            skip_left = 1; phase = P_O_DIG;
                        end else begin
                            phase = P_B_CHECK; again = 1;
                        end
                    end
                    P_O_DIG: begin
                        if (c >= CH_THREE && c <= CH_SEVEN) def_oct = c - 8'h30;
                        skip_left = 1; phase = P_B_CHECK;
                    end
                    P_B_CHECK: begin
                        acc = 0;
                        if (c == CH_LC_B) begin
                            skip_left = 1; phase = P_B_NUM;
                        end else begin
                            phase = P_N_DUR; again = 1;
                        end
                    end
                    P_B_NUM: begin
                        if (digit(c)) add_digit(c);
                        else begin
                            fault    = acc == 0;
                            whole_ms = acc == 0 ? 0 : (60000 / acc) * 4;
                            acc = 0; phase = P_N_DUR;
                        end
                    end
                    P_N_DUR: begin
                        if (digit(c)) add_digit(c);
                        else begin
                            div = acc != 0 ? acc : def_div;
                            if (div == 0) div = 1;
                            p_dur = whole_ms / div;
                            p_semi = note_letter(c);
                            phase = P_N_SHARP;
                        end
                    end
                    P_N_SHARP: begin
                        phase = P_N_DOT;
                        if (c == CH_SHARP) p_semi = (p_semi + 1) & 15;
                        else again = 1;
                    end
                    P_N_DOT: begin
                        phase = P_N_SCALE;
                        if (c == CH_DOT) p_dur = p_dur + p_dur / 2;
                        else again = 1;
                    end
                    P_N_SCALE: begin
                        phase = P_N_COMMA;
                        if (digit(c)) p_oct = c - 8'h30;
                        else begin
                            p_oct = def_oct; again = 1;
                        end
                    end
                    default: begin
                        queue_note();
                        acc = 0; phase = P_N_DUR;
                        if (c != CH_COMMA) again = 1;
                    end
                endcase
            end while (again);
        end
        if (last) begin
            if (phase >= P_N_SHARP) begin
                if (phase != P_N_COMMA) p_oct = def_oct;
                queue_note();
            end
            if (note_q.size() > q_start) note_q[$].last = 1'b1;
            clear_song();
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_song();
            note_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (note_q.size() == 0) begin
                    report("unexpected word", 1, 0);
                end else begin
                    note_t w;
                    w = note_q.pop_front();
                    if (i_is_rest != w.rest) report("is_rest", i_is_rest, w.rest);
                    if (i_semitone != w.semi) report("semitone", i_semitone, w.semi);
                    if (i_octave != w.oct) report("octave", i_octave, w.oct);
                    if (i_pitch_index != w.idx) report("pitch_index", i_pitch_index, w.idx);
                    if (i_index_valid != w.ivalid)
                        report("index_valid", i_index_valid, w.ivalid);
                    if (i_duration_ms != w.dur) report("duration_ms", i_duration_ms, w.dur);
                    if (i_tempo_fault != w.fault)
                        report("tempo_fault", i_tempo_fault, w.fault);
                    if (i_last_note != w.last) report("last_note", i_last_note, w.last);
                end
            end
            if (i_in_valid && !i_in_stall) decode_char(i_melody_char, i_end_of_melody);
        end
    end

endmodule

// ===== tb/tb_rtttl_melody_decoder_top.sv =====
module tb_rtttl_melody_decoder_top;
    import rmd_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic [7:0]  i_melody_char = 0;
    logic        i_end_of_melody = 0;
    logic        i_stall = 0;
    logic        o_stall, o_valid, o_is_rest, o_index_valid, o_tempo_fault, o_last_note;
    logic [3:0]  o_semitone, o_octave;
    logic [5:0]  o_pitch_index;
    logic [18:0] o_duration_ms;
    int          fails, pending;

    // percentages of idle cycles per side, changed between phases
    int send_idle = 0;
    int recv_stall = 0;
    // one long receiver hold-off, requested by stimulus, counted by the receiver
    bit hold_req = 0;
    int chars_sent = 0;
    int quiet = 0;

    always #2 i_clk = ~i_clk;

    rtttl_melody_decoder_top i_dut (.*);

    rmd_checker u_chk (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_melody_char, .i_end_of_melody,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_is_rest(o_is_rest), .i_semitone(o_semitone), .i_octave(o_octave),
        .i_pitch_index(o_pitch_index), .i_index_valid(o_index_valid),
        .i_duration_ms(o_duration_ms), .i_tempo_fault(o_tempo_fault),
        .i_last_note(o_last_note),
        .o_fails(fails), .o_pending(pending)
    );

    // receiver: random stall, plus the single long hold-off
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= $urandom_range(99) < recv_stall;
            end
        end
    end

    // watchdog: cycles without any word moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 3000) begin
            $display("simulation failed");
            $finish;
        end
    end

    typedef byte unsigned song_t[$];

    // one character word, with random gaps ahead of it
    task automatic send_word(input byte unsigned c, input bit last);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_melody_char <= c;
        i_end_of_melody <= last;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
    endtask

    task automatic send_song(input song_t s);
        foreach (s[k]) send_word(s[k], k == s.size() - 1);
    endtask

    function automatic void add_text(ref song_t s, input string t);
        for (int k = 0; k < t.len(); k++) s.push_back(t[k]);
    endfunction

    function automatic void add_num(ref song_t s, input int v);
        add_text(s, $sformatf("%0d", v));
    endfunction

    // mostly well formed ringtones with random content, some noise
    function automatic song_t random_song();
        song_t s;
        string letters;
        int    notes;
        letters = "cdefgabp";
        repeat ($urandom_range(3)) s.push_back(8'($urandom_range(32, 126) == 58 ? 65 :
                                                  $urandom_range(32, 126)));
        if ($urandom_range(9) == 0) s.push_back(8'($urandom_range(255)));
        s.push_back(CH_COLON);
        if ($urandom_range(3) != 0) begin
            add_text(s, "d=");
            case ($urandom_range(5))
                0: add_num(s, 0);
                1: add_num(s, $urandom_range(256, 99999));
                default: add_num(s, 1 << $urandom_range(5));
            endcase
            s.push_back(CH_COMMA);
        end
        if ($urandom_range(3) != 0) begin
            add_text(s, "o=");
            s.push_back(8'($urandom_range(5) == 0 ? $urandom_range(255) :
                           $urandom_range(48, 57)));
            s.push_back(CH_COMMA);
        end
        if ($urandom_range(3) != 0) begin
            add_text(s, "b=");
            case ($urandom_range(9))
                0: add_num(s, 0);
                1: add_num(s, $urandom_range(10000, 999999));
                default: add_num(s, $urandom_range(1, 400));
            endcase
            s.push_back(CH_COLON);
        end
        notes = $urandom_range(1, 8);
        for (int n = 0; n < notes; n++) begin
            if ($urandom_range(1)) add_num(s, $urandom_range(9) == 0 ?
                                           $urandom_range(0, 99999) : 1 << $urandom_range(5));
            s.push_back($urandom_range(9) == 0 ? 8'($urandom_range(255)) :
                        letters[$urandom_range(7)]);
            if ($urandom_range(2) == 0) s.push_back(CH_SHARP);
            if ($urandom_range(2) == 0) s.push_back(CH_DOT);
            if ($urandom_range(1)) s.push_back(8'($urandom_range(48, 57)));
            if (n != notes - 1) s.push_back($urandom_range(19) == 0 ?
                                            8'($urandom_range(255)) : CH_COMMA);
        end
        if ($urandom_range(7) == 0) add_num(s, $urandom_range(99));
        if ($urandom_range(11) == 0) s = s[0:$urandom_range(s.size() - 1)];
        return s;
    endfunction

    initial begin
        song_t s;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: end in the header, a nul in the name
        s = {}; s.push_back(8'h00); add_text(s, "x:d=8"); send_song(s);
        // big and zero header values, sharp pause, dots, odd octaves
        s = {}; add_text(s, "t:d=0,o=3,b=99999:32c#.3,1b7,p#,16a#4,4e9,2f.,8g0,64d");
        send_song(s);
        // zero tempo with a saturated default duration, trailing digits at the end
        s = {}; add_text(s, "z:d=999,o=9,b=0:c,d#,16");
        s.push_back(8'hFF); add_text(s, "p,32");
        send_song(s);
        // slowest tempo with a dotted whole note, end after the octave digit
        s = {}; add_text(s, "q:b=1:1c.,1a#7"); send_song(s);

        for (int ph = 0; ph < 4; ph++) begin
            int goal;
            // wait out the last notes before changing the idling pattern
            i_valid <= 1'b0;
            while (pending != 0) @(posedge i_clk);
            repeat (10) @(posedge i_clk);
            send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 67 : 31) : 0;
            recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 67 : 31) : 0;
            goal = chars_sent + 325;
            if (ph == 0) hold_req = 1;
            while (chars_sent < goal) send_song(random_song());
            // stretch of no idling at the end of the last phase
            if (ph == 3) begin
                send_idle = 0; recv_stall = 0;
                repeat (3) send_song(random_song());
            end
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
